[sv/wnnm_pkg.sv]
// Package: shared types, constants and codes of the weighted nearest-neighbour match block.
package wnnm_pkg;

  localparam int unsigned MaxFacesDefault = 4096;
  localparam int unsigned SumW            = 48;
  localparam int unsigned CoefW           = 32;
  localparam int unsigned LabelW          = 16;
  localparam int unsigned IndexW          = 12;
  localparam int unsigned LimitW          = 31;
  localparam int unsigned UserW           = 15;
  localparam int unsigned DivSteps        = SumW / 2;
  localparam int unsigned DivCntW         = $clog2(DivSteps);

  localparam logic [SumW-1:0]   SumMax       = {SumW{1'b1}};
  localparam logic [LimitW-1:0] LimitReset   = LimitW'(4915200);
  localparam logic [UserW-1:0]  UserIdReset  = UserW'(1);

  // register map: index taken from paddr[2]
  localparam logic RegRejectLimit = 1'b0;
  localparam logic RegUserId      = 1'b1;

  typedef enum logic [1:0] {
    VERDICT_ANON  = 2'd0,
    VERDICT_USER  = 2'd1,
    VERDICT_OTHER = 2'd2
  } wnnm_verdict_e;

  typedef struct packed {
    logic load;
    logic square;
    logic div_init;
    logic div_step;
    logic accumulate;
    logic emit;
  } wnnm_cmd_t;

  typedef struct packed {
    logic last_dim;
    logic last_face;
  } wnnm_status_t;

endpackage

[sv/wnnm_if.sv]
// Interfaces: input item channel and result item channel.
interface wnnm_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] test_coef;
  logic signed [31:0] train_coef;
  logic        [31:0] eigenvalue;
  logic signed [15:0] train_label;
  logic               last_dim;
  logic               last_face;

  modport source (output valid, test_coef, train_coef, eigenvalue, train_label,
                  last_dim, last_face, input ready);
  modport sink   (input valid, test_coef, train_coef, eigenvalue, train_label,
                  last_dim, last_face, output ready);
endinterface

interface wnnm_out_if;
  logic               valid;
  logic               ready;
  logic        [11:0] nearest_index;
  logic signed [15:0] nearest_label;
  logic        [1:0]  verdict;
  logic        [47:0] best_distance;
  logic               none_qualified;

  modport source (output valid, nearest_index, nearest_label, verdict, best_distance,
                  none_qualified, input ready);
  modport sink   (input valid, nearest_index, nearest_label, verdict, best_distance,
                  none_qualified, output ready);
endinterface

[sv/wnnm_ctrl.sv]
// Controller: sequences square, divide and accumulate steps and owns the result handshake.
module wnnm_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  input  wnnm_pkg::wnnm_status_t status_i,
  output wnnm_pkg::wnnm_cmd_t    cmd_o
);
  import wnnm_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SQR,
    S_DINIT,
    S_DIV,
    S_ACC
  } state_e;

  state_e              state_q;
  logic [DivCntW-1:0]  cnt_q;
  logic                out_valid_q;
  logic                scan_end;
  logic                out_free;

  assign scan_end    = status_i.last_dim && status_i.last_face;
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    cmd_o            = '0;
    cmd_o.load       = (state_q == S_IDLE) && in_valid_i;
    cmd_o.square     = (state_q == S_SQR);
    cmd_o.div_init   = (state_q == S_DINIT);
    cmd_o.div_step   = (state_q == S_DIV);
    cmd_o.accumulate = (state_q == S_ACC) && (!scan_end || out_free);
    cmd_o.emit       = (state_q == S_ACC) && scan_end && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_o.emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            state_q <= S_SQR;
          end
        end
        S_SQR: begin
          state_q <= S_DINIT;
        end
        S_DINIT: begin
          cnt_q   <= '0;
          state_q <= S_DIV;
        end
        S_DIV: begin
          cnt_q <= cnt_q + DivCntW'(1);
          if (cnt_q == DivCntW'(DivSteps - 1)) begin
            state_q <= S_ACC;
          end
        end
        S_ACC: begin
          // hold while the final result cannot be handed over
          if (cmd_o.accumulate) begin
            state_q <= S_IDLE;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

endmodule

[sv/wnnm_dpath.sv]
// Datapath: difference, squarer, radix-4 divider, running sum and best-face tracking.
module wnnm_dpath #(
  parameter int unsigned MAX_FACES = wnnm_pkg::MaxFacesDefault
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  wnnm_pkg::wnnm_cmd_t         cmd_i,
  output wnnm_pkg::wnnm_status_t      status_o,
  input  logic signed [31:0]          test_coef_i,
  input  logic signed [31:0]          train_coef_i,
  input  logic        [31:0]          eigenvalue_i,
  input  logic signed [15:0]          train_label_i,
  input  logic                        last_dim_i,
  input  logic                        last_face_i,
  input  logic [wnnm_pkg::LimitW-1:0] reject_limit_i,
  input  logic [wnnm_pkg::UserW-1:0]  user_id_i,
  output logic        [11:0]          nearest_index_o,
  output logic signed [15:0]          nearest_label_o,
  output logic        [1:0]           verdict_o,
  output logic        [47:0]          best_distance_o,
  output logic                        none_qualified_o
);
  import wnnm_pkg::*;

  localparam int unsigned CntW = (MAX_FACES > 1) ? $clog2(MAX_FACES) : 1;

  // item registers
  logic        [31:0] mag_q;
  logic        [31:0] ev_q;
  logic signed [15:0] label_q;
  logic               last_dim_q;
  logic               last_face_q;
  logic        [63:0] sq_q;
  logic        [32:0] rem_q;
  logic        [47:0] num_q;
  logic               sat_q;

  // scan state
  logic [SumW-1:0]    run_q;
  logic               rej_q;
  logic [SumW-1:0]    best_sum_q;
  logic [CntW-1:0]    best_face_q;
  logic signed [15:0] best_person_q;
  logic [CntW-1:0]    count_q;
  logic               found_q;

  logic signed [32:0] diff;
  logic        [32:0] mag33;
  logic               over_limit;
  logic        [32:0] r1;
  logic        [32:0] r1s;
  logic        [32:0] r2;
  logic        [32:0] r2s;
  logic               ge1;
  logic               ge2;
  logic [SumW-1:0]    term;
  logic [SumW:0]      sum49;
  logic [SumW-1:0]    sum_new;
  logic [SumW-1:0]    bs;
  logic [CntW-1:0]    bf;
  logic signed [15:0] bp;
  logic               fa;
  logic               qualify;
  logic [CntW-1:0]    count_next;
  logic [CntW+11:0]   idx_wide;
  wnnm_verdict_e      verdict;

  assign status_o.last_dim  = last_dim_q;
  assign status_o.last_face = last_face_q;

  // exact 33-bit difference and its magnitude
  assign diff       = 33'(test_coef_i) - 33'(train_coef_i);
  assign mag33      = diff[32] ? 33'(-diff) : 33'(diff);
  assign over_limit = mag33 > {2'b00, reject_limit_i};

  // two quotient bits per step
  always_comb begin
    r1  = {rem_q[31:0], num_q[47]};
    ge1 = r1 >= {1'b0, ev_q};
    r1s = ge1 ? (r1 - {1'b0, ev_q}) : r1;
    r2  = {r1s[31:0], num_q[46]};
    ge2 = r2 >= {1'b0, ev_q};
    r2s = ge2 ? (r2 - {1'b0, ev_q}) : r2;
  end

  // saturating accumulate and best-face update
  always_comb begin
    term    = sat_q ? SumMax : num_q;
    sum49   = {1'b0, run_q} + {1'b0, term};
    sum_new = sum49[SumW] ? SumMax : sum49[SumW-1:0];
    bs      = best_sum_q;
    bf      = best_face_q;
    bp      = best_person_q;
    fa      = found_q;
    if ((count_q == '0) && !found_q) begin
      bf = '0;
      bp = label_q;
    end
    qualify = !rej_q && (!found_q || (sum_new < best_sum_q));
    if (qualify) begin
      bs = sum_new;
      bf = count_q;
      bp = label_q;
      fa = 1'b1;
    end
    count_next = (count_q == CntW'(MAX_FACES - 1)) ? '0 : count_q + CntW'(1);
    idx_wide   = {12'b0, bf};
    if (bp <= 16'sd0) begin
      verdict = VERDICT_ANON;
    end else if (bp[14:0] == user_id_i) begin
      verdict = VERDICT_USER;
    end else begin
      verdict = VERDICT_OTHER;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      mag_q       <= mag33[31:0];
      ev_q        <= eigenvalue_i;
      label_q     <= train_label_i;
      last_dim_q  <= last_dim_i;
      last_face_q <= last_face_i;
    end
    if (cmd_i.square) begin
      sq_q <= mag_q * mag_q;
    end
    if (cmd_i.div_init) begin
      // a quotient of 2^48 or more saturates; also covers a zero eigenvalue
      sat_q <= {16'b0, sq_q[63:48]} >= ev_q;
      rem_q <= {17'b0, sq_q[63:48]};
      num_q <= sq_q[47:0];
    end
    if (cmd_i.div_step) begin
      rem_q <= r2s;
      num_q <= {num_q[45:0], ge1, ge2};
    end
    if (cmd_i.emit) begin
      nearest_index_o  <= idx_wide[11:0];
      nearest_label_o  <= bp;
      verdict_o        <= verdict;
      best_distance_o  <= bs;
      none_qualified_o <= !fa;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q         <= '0;
      rej_q         <= 1'b0;
      best_sum_q    <= SumMax;
      best_face_q   <= '0;
      best_person_q <= '0;
      count_q       <= '0;
      found_q       <= 1'b0;
    end else begin
      if (cmd_i.load && over_limit) begin
        rej_q <= 1'b1;
      end
      if (cmd_i.accumulate) begin
        if (!last_dim_q) begin
          run_q <= sum_new;
        end else if (last_face_q) begin
          // end of scan: back to the reset picture
          run_q         <= '0;
          rej_q         <= 1'b0;
          best_sum_q    <= SumMax;
          best_face_q   <= '0;
          best_person_q <= '0;
          count_q       <= '0;
          found_q       <= 1'b0;
        end else begin
          run_q         <= '0;
          rej_q         <= 1'b0;
          best_sum_q    <= bs;
          best_face_q   <= bf;
          best_person_q <= bp;
          count_q       <= count_next;
          found_q       <= fa;
        end
      end
    end
  end

endmodule

[sv/weighted_nearest_neighbor_match.sv]
// Top level: weighted nearest-neighbour match with configuration port.
//
// Usage: stream one item per dimension of each training face on in_i (test and
// training coefficient, eigenvalue, face label, last_dim, last_face). Each face
// sums the saturated terms (test - train)^2 / eigenvalue in Q36.12; a face with
// any |test - train| above reject_limit is disqualified. When an item carries
// both last_dim and last_face, one result item leaves on out_o with the nearest
// face index, its label, the verdict, the distance and a none-qualified flag.
// Each item goes through accept, square, divider set-up, 24 radix-4 divider steps
// and accumulate; the shared 48-bit quotient divider takes a new item only after that.
// The result is registered at the accumulate step of the final item.
// A stalled result sits in the output register while the next scan streams on;
// only the final item of the following scan waits for it to be taken.
// Configuration (APB): reject_limit at 0x0, user_id at 0x4; write only while idle.
// Reset clears the scan state and the result valid, and loads the register
// defaults (reject_limit 1200.0, user_id 1).
module weighted_nearest_neighbor_match #(
  parameter int unsigned MAX_FACES = wnnm_pkg::MaxFacesDefault
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  wnnm_in_if.sink     in_i,
  wnnm_out_if.source  out_o,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import wnnm_pkg::*;

  logic [LimitW-1:0] reject_limit_q;
  logic [UserW-1:0]  user_id_q;
  logic              cfg_write;
  wnnm_cmd_t         cmd;
  wnnm_status_t      status;

  // configuration registers
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_comb begin
    case (paddr[2])
      RegRejectLimit: prdata = {1'b0, reject_limit_q};
      RegUserId:      prdata = {17'b0, user_id_q};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      reject_limit_q <= LimitReset;
      user_id_q      <= UserIdReset;
    end else if (cfg_write) begin
      case (paddr[2])
        RegRejectLimit: reject_limit_q <= pwdata[LimitW-1:0];
        RegUserId:      user_id_q      <= pwdata[UserW-1:0];
        default:        ;
      endcase
    end
  end

  // sequence the steps of each item
  wnnm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // arithmetic, scan state and the result register
  wnnm_dpath #(
    .MAX_FACES (MAX_FACES)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .test_coef_i      (in_i.test_coef),
    .train_coef_i     (in_i.train_coef),
    .eigenvalue_i     (in_i.eigenvalue),
    .train_label_i    (in_i.train_label),
    .last_dim_i       (in_i.last_dim),
    .last_face_i      (in_i.last_face),
    .reject_limit_i   (reject_limit_q),
    .user_id_i        (user_id_q),
    .nearest_index_o  (out_o.nearest_index),
    .nearest_label_o  (out_o.nearest_label),
    .verdict_o        (out_o.verdict),
    .best_distance_o  (out_o.best_distance),
    .none_qualified_o (out_o.none_qualified)
  );

  // one item in flight at a time
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_i.valid && in_i.ready) |=> !in_i.ready)
    else $error("input accepted while an item is still in flight");

  // never overwrite a result that has not been taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.emit |-> (!out_o.valid || out_o.ready))
    else $error("result overwritten before it was taken");

  // an empty scan reports the saturated distance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.none_qualified) |-> (&out_o.best_distance))
    else $error("none qualified but distance not saturated");

endmodule
